### sv/csp_pkg.sv
// Shared types and constants for the CAN signal packer.
package csp_pkg;

  // Field widths of one signal beat.
  localparam int VAL_W   = 48;
  localparam int FAC_W   = 47;
  localparam int RAW_W   = 48;
  localparam int START_W = 6;
  localparam int LEN_W   = 7;
  localparam int FRAME_W = 64;
  localparam int CNT_W   = 6;

  // Longest signal that fits the 64-bit frame.
  localparam logic [LEN_W-1:0] MAX_LEN = 7'd64;

  // Sequencer states of the top level.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CLAMP_LO,
    ST_CLAMP_HI,
    ST_SUB,
    ST_DIV,
    ST_PLACE,
    ST_EMIT
  } csp_state_t;

  // Commands from the sequencer to the bit placer.
  typedef struct packed {
    logic load;
    logic clear;
  } csp_place_cmd_t;

  // Status returned by the bit placer.
  typedef struct packed {
    logic busy;
    logic error;
  } csp_place_stat_t;

endpackage

### sv/csp_divider.sv
// Restoring divider that produces one quotient bit per cycle.
module csp_divider
  import csp_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [RAW_W-1:0] dividend,
  input  logic [FAC_W-1:0] divisor,
  output logic             done,
  output logic [RAW_W-1:0] quotient
);

  logic [FAC_W-1:0] div_r;
  logic [FAC_W-1:0] rem_r, rem_nxt;
  logic [RAW_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             done_r, done_nxt;
  logic [RAW_W-1:0] trial;
  logic [RAW_W-1:0] diff;
  logic             fits;

  // One restoring step: shift in the next dividend bit and try the subtract.
  // The remainder stays below the divisor, so it fits the divisor width.
  always_comb begin
    trial = {rem_r, quo_r[RAW_W-1]};
    fits  = trial >= {1'b0, div_r};
    diff  = trial - {1'b0, div_r};
  end

  // Next-value logic for the step counter, remainder and quotient.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt = '0;
      quo_nxt = dividend;
      cnt_nxt = CNT_W'(RAW_W);
    end else if (cnt_r != '0) begin
      rem_nxt  = fits ? diff[FAC_W-1:0] : trial[FAC_W-1:0];
      quo_nxt  = {quo_r[RAW_W-2:0], fits};
      cnt_nxt  = cnt_r - 1'b1;
      done_nxt = (cnt_r == CNT_W'(1));
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

`ifndef SYNTHESIS
  // A finished division follows the last step of the counter.
  a_done_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> cnt_r == '0)
    else $error("divider done without finishing its steps");

  // A start loads the full step count.
  a_start_loads: assert property (@(posedge clk) disable iff (!rst_n)
    start |=> cnt_r == CNT_W'(RAW_W))
    else $error("divider start did not load the step count");

  // The remainder never reaches the divisor while steps run.
  a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !$past(start)) |-> rem_r < div_r)
    else $error("divider remainder out of range");
`endif

endmodule

### sv/csp_placer.sv
// Serial bit placer that ORs raw bits into the frame accumulator.
module csp_placer
  import csp_pkg::*;
#(
  parameter int NBYTES = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  csp_place_cmd_t     cmd,
  input  logic [RAW_W-1:0]   raw,
  input  logic [START_W-1:0] start_bit,
  input  logic [LEN_W-1:0]   bit_length,
  input  logic               motorola_order,
  output csp_place_stat_t    stat,
  output logic [FRAME_W-1:0] frame
);

  logic [FRAME_W-1:0] acc_r, acc_nxt;
  logic               err_r, err_nxt;
  logic [RAW_W-1:0]   raw_r, raw_nxt;
  logic [LEN_W-1:0]   cnt_r, cnt_nxt;
  logic [4:0]         byte_r, byte_nxt;
  logic [2:0]         bit_r, bit_nxt;
  logic               moto_r, moto_nxt;
  logic               in_frame;
  logic [5:0]         pos;

  // The byte index runs from minus one to eight; both ends stay put.
  always_comb begin
    in_frame = !byte_r[4] && (byte_r < 5'(NBYTES));
    pos      = {byte_r[2:0], bit_r};
  end

  // One raw bit placed per cycle while the count runs.
  always_comb begin
    acc_nxt  = acc_r;
    err_nxt  = err_r;
    raw_nxt  = raw_r;
    cnt_nxt  = cnt_r;
    byte_nxt = byte_r;
    bit_nxt  = bit_r;
    moto_nxt = moto_r;
    if (cmd.clear) begin
      acc_nxt = '0;
      err_nxt = 1'b0;
    end else if (cmd.load) begin
      raw_nxt  = raw;
      cnt_nxt  = (bit_length > MAX_LEN) ? MAX_LEN : bit_length;
      byte_nxt = {2'b00, start_bit[5:3]};
      bit_nxt  = start_bit[2:0];
      moto_nxt = motorola_order;
    end else if (cnt_r != '0) begin
      if (in_frame) begin
        acc_nxt[pos] = acc_r[pos] | raw_r[0];
      end else begin
        err_nxt = 1'b1;
      end
      raw_nxt = {1'b0, raw_r[RAW_W-1:1]};
      cnt_nxt = cnt_r - 1'b1;
      bit_nxt = bit_r + 1'b1;
      if (bit_r == 3'd7) begin
        if (moto_r) begin
          if (!byte_r[4]) begin
            byte_nxt = byte_r - 1'b1;
          end
        end else if (byte_r != 5'd8) begin
          byte_nxt = byte_r + 1'b1;
        end
      end
    end
  end

  // Frame state and count are control state cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
      err_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      err_r <= err_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Working registers of the current signal.
  always_ff @(posedge clk) begin
    raw_r  <= raw_nxt;
    byte_r <= byte_nxt;
    bit_r  <= bit_nxt;
    moto_r <= moto_nxt;
  end

  assign stat.busy  = (cnt_r != '0);
  assign stat.error = err_r;
  assign frame      = acc_r;

`ifndef SYNTHESIS
  // A clear empties the frame and the error flag.
  a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.clear |=> acc_r == '0 && !err_r)
    else $error("placer clear left frame state behind");

  // The count never exceeds the frame width.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= MAX_LEN)
    else $error("placer count out of range");

  // Placing a bit only ever sets frame bits.
  a_acc_grows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r != '0 && !cmd.clear && !cmd.load) |=> (acc_r & $past(acc_r)) == $past(acc_r))
    else $error("placer dropped a frame bit");
`endif

endmodule

### sv/can_signal_packer.sv
// Top level of the CAN signal packer: sequencer, output register and units.
//
// One signal descriptor is accepted per beat while the block is idle; the
// value is clamped, reduced by the offset and divided by the scale factor,
// and its raw bits are ORed into an 8-byte frame one bit per cycle. A signal
// is captured, clamped to the lower and then the upper limit and reduced by
// the offset; the bit-serial divider runs only when the offset-reduced value
// is positive, then the serial placer places bit_length bits (bit_length
// saturates at 64), and a last signal hands off its frame beat, waiting while
// the output register is still stalled. in_stall stays high from the
// accepting edge until the sequencer is idle. A frame beat waits in an
// output register; bits placed outside the frame are dropped and reported
// by placement_error with that frame.
module can_signal_packer
  import csp_pkg::*;
#(
  parameter int FRAME_BYTES = 8
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [VAL_W-1:0]   in_physical_value,
  input  logic signed [VAL_W-1:0]   in_min_limit,
  input  logic signed [VAL_W-1:0]   in_max_limit,
  input  logic signed [VAL_W-1:0]   in_value_offset,
  input  logic [FAC_W-1:0]          in_scale_factor,
  input  logic [START_W-1:0]        in_start_bit,
  input  logic [LEN_W-1:0]          in_bit_length,
  input  logic                      in_motorola_order,
  input  logic                      in_last_signal,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [FRAME_W-1:0]        out_frame_data,
  output logic                      out_placement_error
);

  localparam int NBYTES = (FRAME_BYTES < 8) ? FRAME_BYTES : 8;

  csp_state_t state_r, state_nxt;

  logic signed [VAL_W-1:0] v_r, v_nxt;
  logic signed [VAL_W-1:0] lo_r, hi_r, off_r;
  logic [FAC_W-1:0]        fac_r;
  logic [START_W-1:0]      start_r;
  logic [LEN_W-1:0]        len_r;
  logic                    moto_r;
  logic                    last_r;

  logic signed [VAL_W:0]   diff;
  logic                    diff_pos;

  logic                    div_start;
  logic                    div_done;
  logic [RAW_W-1:0]        quotient;
  logic [RAW_W-1:0]        place_raw;

  csp_place_cmd_t          pcmd;
  csp_place_stat_t         pstat;
  logic [FRAME_W-1:0]      frame;

  logic                    out_valid_r, out_valid_nxt;
  logic [FRAME_W-1:0]      out_data_r;
  logic                    out_err_r;
  logic                    out_free;
  logic                    in_take;

  assign in_take  = in_valid && (state_r == ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Offset subtraction; positive only when nonzero and sign clear.
  always_comb begin
    diff     = {v_r[VAL_W-1], v_r} - {off_r[VAL_W-1], off_r};
    diff_pos = !diff[VAL_W] && (diff != '0);
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_CLAMP_LO;
      ST_CLAMP_LO: state_nxt = ST_CLAMP_HI;
      ST_CLAMP_HI: state_nxt = ST_SUB;
      ST_SUB:      state_nxt = diff_pos ? ST_DIV : ST_PLACE;
      ST_DIV:      if (div_done) state_nxt = ST_PLACE;
      ST_PLACE: begin
        if (!pstat.busy) begin
          state_nxt = last_r ? ST_EMIT : ST_IDLE;
        end
      end
      ST_EMIT:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs to the units.
  always_comb begin
    div_start  = 1'b0;
    pcmd.load  = 1'b0;
    pcmd.clear = 1'b0;
    place_raw  = quotient;
    case (state_r)
      ST_SUB: begin
        div_start = diff_pos;
        pcmd.load = !diff_pos;
        place_raw = '0;
      end
      ST_DIV:  pcmd.load  = div_done;
      ST_EMIT: pcmd.clear = out_free;
      default: ;
    endcase
  end

  // Clamp: raise to the lower limit, then lower to the upper limit.
  always_comb begin
    v_nxt = v_r;
    case (state_r)
      ST_IDLE:     v_nxt = in_physical_value;
      ST_CLAMP_LO: if (v_r < lo_r) v_nxt = lo_r;
      ST_CLAMP_HI: if (v_r > hi_r) v_nxt = hi_r;
      default:     ;
    endcase
  end

  // Output register next valid.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_valid_nxt = 1'b1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Captured descriptor and output payload.
  always_ff @(posedge clk) begin
    v_r <= v_nxt;
    if (in_take) begin
      lo_r    <= in_min_limit;
      hi_r    <= in_max_limit;
      off_r   <= in_value_offset;
      fac_r   <= (in_scale_factor == '0) ? FAC_W'(1) : in_scale_factor;
      start_r <= in_start_bit;
      len_r   <= in_bit_length;
      moto_r  <= in_motorola_order;
      last_r  <= in_last_signal;
    end
    if (state_r == ST_EMIT && out_free) begin
      out_data_r <= frame;
      out_err_r  <= pstat.error;
    end
  end

  csp_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (diff[RAW_W-1:0]),
    .divisor  (fac_r),
    .done     (div_done),
    .quotient (quotient)
  );

  csp_placer #(
    .NBYTES (NBYTES)
  ) u_place (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (pcmd),
    .raw            (place_raw),
    .start_bit      (start_r),
    .bit_length     (len_r),
    .motorola_order (moto_r),
    .stat           (pstat),
    .frame          (frame)
  );

  assign in_stall            = (state_r != ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_frame_data      = out_data_r;
  assign out_placement_error = out_err_r;

`ifndef SYNTHESIS
  // An accepted beat starts the clamp sequence.
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> state_r == ST_CLAMP_LO)
    else $error("accepted beat did not start the sequence");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == ST_DIV)
    else $error("divider finished outside the divide state");

  // The placer only runs while the sequencer is in the place state.
  a_place_state: assert property (@(posedge clk) disable iff (!rst_n)
    pstat.busy |-> state_r == ST_PLACE)
    else $error("placer busy outside the place state");

  // An emitted frame shows up as a valid beat and frees the block.
  a_emit_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_free) |=> out_valid && state_r == ST_IDLE)
    else $error("frame beat not presented after emit");
`endif

endmodule

### bench/frame_packing_checker.sv
`timescale 1ns / 1ps
// Checker for the CAN signal packer: predicts every frame beat and compares the result channel.
module frame_packing_checker
  import csp_pkg::*;
#(
  parameter int FRAME_BYTES = 8
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_stall,
  input  logic signed [VAL_W-1:0] in_physical_value,
  input  logic signed [VAL_W-1:0] in_min_limit,
  input  logic signed [VAL_W-1:0] in_max_limit,
  input  logic signed [VAL_W-1:0] in_value_offset,
  input  logic [FAC_W-1:0]        in_scale_factor,
  input  logic [START_W-1:0]      in_start_bit,
  input  logic [LEN_W-1:0]        in_bit_length,
  input  logic                    in_motorola_order,
  input  logic                    in_last_signal,
  input  logic                    out_valid,
  input  logic                    out_stall,
  input  logic [FRAME_W-1:0]      out_frame_data,
  input  logic                    out_placement_error,
  output int                      fail_count,
  output int                      frames_checked,
  output int                      flagged_frames,
  output int                      frames_pending
);

  // The accumulator is 64 bits, so the usable frame never exceeds 8 bytes.
  localparam int FRAME_SPAN = (FRAME_BYTES < 8) ? FRAME_BYTES : 8;

  typedef struct {
    logic [FRAME_W-1:0] data;
    logic               error;
  } frame_t;

  frame_t             expected_frames[$];
  logic [FRAME_W-1:0] frame_acc = '0;
  logic               frame_err = 1'b0;
  int                 mismatches = 0;
  int                 checked = 0;
  int                 flagged = 0;

  // Clamp, remove the offset and divide; a non-positive difference gives zero.
  function automatic logic [FRAME_W-1:0] raw_value(input logic signed [VAL_W-1:0] v,
                                                   input logic signed [VAL_W-1:0] lo,
                                                   input logic signed [VAL_W-1:0] hi,
                                                   input logic signed [VAL_W-1:0] off,
                                                   input logic [FAC_W-1:0] fac);
    longint             x;
    longint             diff;
    logic [FRAME_W-1:0] num;
    logic [FRAME_W-1:0] den;
    x = longint'(v);
    if (x < lo) x = longint'(lo);
    if (x > hi) x = longint'(hi);
    diff = x - longint'(off);
    if (diff <= 0) return '0;
    num = diff;
    den = (fac == '0) ? 64'd1 : {17'd0, fac};
    return num / den;
  endfunction

  // Walk the bit position and OR each raw bit into the frame, flagging bits
  // whose byte lies outside it.
  function automatic void place_bits(input logic [FRAME_W-1:0] raw,
                                     input logic [START_W-1:0] start,
                                     input logic [LEN_W-1:0]   len,
                                     input logic               moto);
    int byte_idx;
    int bit_idx;
    int count;
    byte_idx = int'(start[5:3]);
    bit_idx = int'(start[2:0]);
    count = (len > MAX_LEN) ? int'(MAX_LEN) : int'(len);
    for (int i = 0; i < count; i++) begin
      if (byte_idx >= 0 && byte_idx < FRAME_SPAN) begin
        frame_acc[byte_idx * 8 + bit_idx] |= raw[i];
      end else begin
        frame_err = 1'b1;
      end
      bit_idx++;
      if (bit_idx == 8) begin
        bit_idx = 0;
        if (moto) begin
          if (byte_idx >= 0) byte_idx--;
        end else if (byte_idx < 8) begin
          byte_idx++;
        end
      end
    end
  endfunction

  task automatic report(input string field, input logic [FRAME_W-1:0] want_v,
                        input logic [FRAME_W-1:0] got_v);
    mismatches++;
    if (mismatches <= 10) begin
      $display("Mismatch in %s at %0t: expected %h, got %h", field, $realtime, want_v, got_v);
    end
  endtask

  // Result beats are checked before the input beat of the same edge is
  // predicted; a signal never finishes in the cycle it is taken.
  always @(posedge clk) begin : check_beats
    frame_t want;
    if (!rst_n) begin
      frame_acc = '0;
      frame_err = 1'b0;
      expected_frames.delete();
    end else begin
      if (out_valid && !out_stall) begin
        checked++;
        if (out_placement_error) flagged++;
        if (expected_frames.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Unexpected frame beat at %0t: frame %h error %b", $realtime,
                     out_frame_data, out_placement_error);
          end
        end else begin
          want = expected_frames.pop_front();
          if (out_frame_data !== want.data) begin
            report("frame_data", want.data, out_frame_data);
          end
          if (out_placement_error !== want.error) begin
            report("placement_error", 64'(want.error), 64'(out_placement_error));
          end
        end
      end
      if (in_valid && !in_stall) begin
        place_bits(raw_value(in_physical_value, in_min_limit, in_max_limit, in_value_offset,
                             in_scale_factor),
                   in_start_bit, in_bit_length, in_motorola_order);
        if (in_last_signal) begin
          want.data = frame_acc;
          want.error = frame_err;
          expected_frames.push_back(want);
          frame_acc = '0;
          frame_err = 1'b0;
        end
      end
    end
    fail_count <= mismatches;
    frames_checked <= checked;
    flagged_frames <= flagged;
    frames_pending <= expected_frames.size();
  end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Top of the CAN signal packer bench: clock, reset, signal and stall stimulus, verdict.
module testbench
  import csp_pkg::*;
();

  localparam int FRAME_BYTES    = 8;
  localparam int RANDOM_SIGNALS = 650;
  localparam int QUIET_LIMIT    = 4000;
  localparam int DRAIN_CYCLES   = 150;
  localparam int LONG_HOLD      = 900;

  localparam logic signed [VAL_W-1:0] VAL_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 48'sh8000_0000_0000;
  localparam logic [FAC_W-1:0]        FAC_MAX = '1;
  localparam logic [FAC_W-1:0]        FAC_ONE = 47'h1_0000;

  typedef struct {
    logic signed [VAL_W-1:0] value;
    logic signed [VAL_W-1:0] lo_limit;
    logic signed [VAL_W-1:0] hi_limit;
    logic signed [VAL_W-1:0] offset;
    logic [FAC_W-1:0]        factor;
    logic [START_W-1:0]      start;
    logic [LEN_W-1:0]        length;
    logic                    moto;
    logic                    last;
  } signal_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [VAL_W-1:0] in_physical_value = '0;
  logic signed [VAL_W-1:0] in_min_limit = '0;
  logic signed [VAL_W-1:0] in_max_limit = '0;
  logic signed [VAL_W-1:0] in_value_offset = '0;
  logic [FAC_W-1:0]        in_scale_factor = '0;
  logic [START_W-1:0]      in_start_bit = '0;
  logic [LEN_W-1:0]        in_bit_length = '0;
  logic                    in_motorola_order = 1'b0;
  logic                    in_last_signal = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic [FRAME_W-1:0]      out_frame_data;
  logic                    out_placement_error;

  int fail_count;
  int frames_checked;
  int flagged_frames;
  int frames_pending;
  int signals_sent = 0;
  int quiet_cycles = 0;
  bit idle_on = 1'b1;

  can_signal_packer #(.FRAME_BYTES(FRAME_BYTES)) uut (.*);

  frame_packing_checker #(.FRAME_BYTES(FRAME_BYTES)) checker_i (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Watchdog: the run ends if neither channel moves a beat for too long.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic signed [VAL_W-1:0] rand48();
    logic signed [VAL_W-1:0] r;
    r[47:16] = $urandom;
    r[15:0] = 16'($urandom_range(0, 65535));
    return r;
  endfunction

  // Whole number n in Q32.16.
  function automatic logic signed [VAL_W-1:0] q(input longint n);
    logic signed [VAL_W-1:0] r;
    r = VAL_W'(n * 65536);
    return r;
  endfunction

  function automatic signal_t sig(input logic signed [VAL_W-1:0] v, lo, hi, off,
                                  input logic [FAC_W-1:0] fac, input int start, len,
                                  input bit moto, last);
    signal_t s;
    s.value = v;
    s.lo_limit = lo;
    s.hi_limit = hi;
    s.offset = off;
    s.factor = fac;
    s.start = START_W'(start);
    s.length = LEN_W'(len);
    s.moto = moto;
    s.last = last;
    return s;
  endfunction

  // Plausible signal: ordered limits, modest offset and factor, mostly short fields.
  function automatic signal_t shaped_signal(input bit last);
    signal_t                 s;
    logic signed [VAL_W-1:0] a;
    logic signed [VAL_W-1:0] b;
    a = rand48() >>> $urandom_range(8, 47);
    b = rand48() >>> $urandom_range(8, 47);
    s.lo_limit = (a < b) ? a : b;
    s.hi_limit = (a < b) ? b : a;
    s.value = rand48() >>> $urandom_range(0, 47);
    s.offset = rand48() >>> $urandom_range(20, 47);
    s.factor = FAC_W'($urandom_range(1, 1 << $urandom_range(0, 24)));
    s.start = START_W'($urandom_range(0, 63));
    s.length = ($urandom_range(0, 7) == 0) ? LEN_W'($urandom_range(17, 64))
                                            : LEN_W'($urandom_range(1, 16));
    s.moto = 1'($urandom_range(0, 1));
    s.last = last;
    return s;
  endfunction

  // Unconstrained signal: every field drawn over its full width.
  function automatic signal_t noise_signal();
    signal_t s;
    s.value = rand48();
    s.lo_limit = rand48();
    s.hi_limit = rand48();
    s.offset = rand48();
    s.factor = FAC_W'(rand48());
    s.start = START_W'($urandom_range(0, 63));
    s.length = LEN_W'($urandom_range(0, 127));
    s.moto = 1'($urandom_range(0, 1));
    s.last = 1'($urandom_range(0, 1));
    return s;
  endfunction

  // Offer one signal beat, after a random gap when gaps are on, and hold it until it is taken.
  task automatic send_beat(input signal_t s);
    int gap;
    gap = idle_on ? $urandom_range(0, 16) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_physical_value <= s.value;
    in_min_limit <= s.lo_limit;
    in_max_limit <= s.hi_limit;
    in_value_offset <= s.offset;
    in_scale_factor <= s.factor;
    in_start_bit <= s.start;
    in_bit_length <= s.length;
    in_motorola_order <= s.moto;
    in_last_signal <= s.last;
    do @(posedge clk); while (in_stall);
    signals_sent++;
  endtask

  // Result side: random stall before each frame beat, and one long hold so
  // that the packer backs up and stalls its input.
  initial begin
    int hold;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (taken == 12) hold = LONG_HOLD;
      else hold = idle_on ? $urandom_range(0, 16) : 0;
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      taken++;
    end
  end

  initial begin
    signal_t s;
    int      nsig;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: plain Intel byte, then a Motorola word closing the frame.
    send_beat(sig(q(8'h5A), VAL_MIN, VAL_MAX, '0, FAC_ONE, 0, 8, 0, 0));
    send_beat(sig(q(16'hBEEF), VAL_MIN, VAL_MAX, '0, FAC_ONE, 8, 16, 1, 1));
    // Crossed limits, then clamping from below and from above.
    send_beat(sig(q(5), q(10), q(3), '0, FAC_ONE, 0, 8, 0, 1));
    send_beat(sig(q(-100), q(2), q(50), '0, FAC_ONE, 16, 8, 0, 0));
    send_beat(sig(q(1000), '0, q(200), '0, FAC_ONE, 24, 8, 0, 1));
    // Zero factor counts as one.
    send_beat(sig(48'sh1234, VAL_MIN, VAL_MAX, '0, '0, 0, 16, 0, 1));
    // Negative and zero differences give a raw value of zero.
    send_beat(sig(q(-5), VAL_MIN, VAL_MAX, '0, FAC_ONE, 0, 8, 0, 0));
    send_beat(sig(q(7), VAL_MIN, VAL_MAX, q(7), FAC_ONE, 8, 8, 0, 1));
    // Lengths above 64 saturate; from bit 0 they just fill the frame.
    send_beat(sig(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, '0, 0, 127, 0, 1));
    send_beat(sig(VAL_MAX, VAL_MIN, VAL_MAX, '0, 47'd1, 8, 65, 0, 1));
    // Zero length places nothing and raises no error.
    send_beat(sig(VAL_MAX, VAL_MIN, VAL_MAX, '0, 47'd1, 63, 0, 1, 1));
    // Motorola running below byte 0, Intel running past the end.
    send_beat(sig(48'sh3FF, VAL_MIN, VAL_MAX, '0, 47'd1, 0, 10, 1, 1));
    send_beat(sig(48'shF, VAL_MIN, VAL_MAX, '0, 47'd1, 60, 8, 0, 1));
    // Field extremes, including zero bits that still fall outside the frame.
    send_beat(sig(VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, FAC_MAX, 63, 64, 1, 1));
    send_beat(sig(VAL_MAX, VAL_MIN, VAL_MAX, VAL_MIN, FAC_MAX, 0, 64, 0, 1));
    send_beat(sig(VAL_MAX, VAL_MIN, VAL_MAX, '0, 47'd1, 63, 127, 1, 0));
    send_beat(sig(q(-1), VAL_MIN, VAL_MAX, '0, FAC_ONE, 56, 16, 0, 1));

    // Random frames of well-formed signals, with some unconstrained noise.
    while (signals_sent < RANDOM_SIGNALS) begin
      idle_on = ((signals_sent / 120) % 3) != 1;
      nsig = $urandom_range(1, 6);
      for (int k = 0; k < nsig; k++) begin
        if ($urandom_range(0, 9) == 0) s = noise_signal();
        else s = shaped_signal(k == nsig - 1);
        send_beat(s);
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // Drain outstanding frames, then allow for the packer's longest signal.
    while (frames_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d signal beats and %0d frame beats, %0d flagged out of frame.",
             signals_sent, frames_checked, flagged_frames);
    $display("Mismatches: %0d, frames still expected: %0d", fail_count, frames_pending);
    if (fail_count == 0 && frames_pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
